>>> design/smct_pkg.sv
// Shared types and codes for the sorted multiset count table.
// No dependencies. The cell chain and the top level import this package.
package smct_pkg;

    // Operation codes carried on the input stream.
    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_COUNT      = 3'd1;
    localparam logic [2:0] OP_REMOVE_ONE = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
    localparam logic [2:0] OP_MIN_RUN    = 3'd4;

    // Status codes carried on the output stream.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;
    localparam logic [1:0] STAT_SAT    = 2'd3;

    // Fixed widths of the stream fields.
    localparam int OP_W   = 3;
    localparam int KEY_W  = 32;
    localparam int MULT_W = 16;
    localparam int DIST_W = 5;
    localparam int STAT_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIN,
        ST_EMIT
    } t_state;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_UPDATE,
        ACT_INSERT,
        ACT_DROP
    } t_cell_act;

    typedef struct packed {
        t_cell_act act;
    } t_cell_cmd;

endpackage

>>> design/smct_cell.sv
// One slot of the sorted table: key, count and valid flag.
// Depends on smct_pkg for the broadcast command type.
module smct_cell #(
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smct_pkg::t_cell_cmd   i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [KEY_BITS-1:0]   i_left_key,
    input  logic [COUNT_BITS-1:0] i_left_count,
    input  logic                  i_left_valid,
    input  logic                  i_left_lt,
    input  logic [KEY_BITS-1:0]   i_right_key,
    input  logic [COUNT_BITS-1:0] i_right_count,
    input  logic                  i_right_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_valid,
    output logic                  o_lt,
    output logic                  o_eq
);
    import smct_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_valid;
    logic [KEY_BITS-1:0]   n_key;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_valid;

    // Compare against the broadcast key; empty slots are never below it.
    assign o_lt    = r_valid && (r_key < i_key);
    assign o_eq    = r_valid && (r_key == i_key);
    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_valid = r_valid;

    // Slots at or after the search position shift towards or away from
    // the neighbours; the matching slot takes the new count.
    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        n_valid = r_valid;
        unique case (i_cmd.act)
            ACT_UPDATE: begin
                if (o_eq) begin
                    n_count = i_count;
                end
            end
            ACT_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_key   = i_key;
                        n_count = i_count;
                        n_valid = 1'b1;
                    end else begin
                        n_key   = i_left_key;
                        n_count = i_left_count;
                        n_valid = i_left_valid;
                    end
                end
            end
            ACT_DROP: begin
                if (!o_lt) begin
                    n_key   = i_right_key;
                    n_count = i_right_count;
                    n_valid = i_right_valid;
                end
            end
            default: begin
            end
        endcase
    end

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Slot payload.
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

endmodule

>>> design/sorted_multiset_count_table.sv
// Top level of the sorted multiset count table: a chain of smct_cell slots,
// the operation decoder, the minimum-run sequencer and the output register.
// Depends on smct_pkg and smct_cell.
//
// Channel   Direction  Transaction moves
// s_axis    in         tdata = op[2:0], key[34:3]
// m_axis    out        tdata = multiplicity[15:0], key_out[47:16], distinct[52:48],
//                      status[54:53]; tlast = last result of the run
//
// Add, count, remove one and remove all: all slots compare in parallel and
// the result is registered at the accepting edge.
// A minimum run finds the minimum, one slot a cycle through the scan counter,
// then scans up to the last match one slot a cycle, holding a match while m_axis stalls.
// Reset (synchronous, active low) empties the table; no clearing pass.
// A stalled output holds the input and the emit pass; s_axis_tready is low during a run.
module sorted_multiset_count_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [smct_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // op, key
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [smct_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // mult, key, distinct, status
    output logic                              m_axis_tlast
);
    import smct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Cell chain outputs.
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [COUNT_BITS-1:0] w_cnt   [ENTRIES];
    logic                  w_valid [ENTRIES];
    logic                  w_lt    [ENTRIES];
    logic                  w_eq    [ENTRIES];

    t_cell_cmd             w_cmd;
    logic [COUNT_BITS-1:0] w_new_count;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [OP_W-1:0]       w_op;

    // Sequencer and output registers.
    t_state                r_state, n_state;
    logic [OW-1:0]         r_occ, n_occ;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_last_idx, n_last_idx;
    logic [COUNT_BITS-1:0] r_min, n_min;
    logic                  r_mval, n_mval;
    logic [MULT_W-1:0]     r_mult, n_mult;
    logic [KEY_W-1:0]      r_mkey, n_mkey;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic [STAT_W-1:0]     r_stat, n_stat;
    logic                  r_last, n_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_found;
    logic [COUNT_BITS-1:0] w_found_cnt;
    logic [COUNT_BITS-1:0] w_scan_cnt;
    logic [KEY_BITS-1:0]   w_scan_key;

    assign w_op     = s_axis_tdata[OP_W-1:0];
    assign w_in_key = KEY_BITS'(s_axis_tdata[OP_W+KEY_W-1:OP_W]);

    assign w_out_free    = !r_mval || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Chain of slots; the ends see a boundary that is below every key on the
    // left and empty on the right.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]   l_key;
        logic [COUNT_BITS-1:0] l_cnt;
        logic                  l_valid;
        logic                  l_lt;
        logic [KEY_BITS-1:0]   r_nkey;
        logic [COUNT_BITS-1:0] r_ncnt;
        logic                  r_nvalid;

        if (g == 0) begin : g_left_end
            assign l_key   = '0;
            assign l_cnt   = '0;
            assign l_valid = 1'b0;
            assign l_lt    = 1'b1;
        end else begin : g_left
            assign l_key   = w_key[g-1];
            assign l_cnt   = w_cnt[g-1];
            assign l_valid = w_valid[g-1];
            assign l_lt    = w_lt[g-1];
        end

        if (g == ENTRIES - 1) begin : g_right_end
            assign r_nkey   = '0;
            assign r_ncnt   = '0;
            assign r_nvalid = 1'b0;
        end else begin : g_right
            assign r_nkey   = w_key[g+1];
            assign r_ncnt   = w_cnt[g+1];
            assign r_nvalid = w_valid[g+1];
        end

        smct_cell #(
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_key         (w_in_key),
            .i_count       (w_new_count),
            .i_left_key    (l_key),
            .i_left_count  (l_cnt),
            .i_left_valid  (l_valid),
            .i_left_lt     (l_lt),
            .i_right_key   (r_nkey),
            .i_right_count (r_ncnt),
            .i_right_valid (r_nvalid),
            .o_key         (w_key[g]),
            .o_count       (w_cnt[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // Count of the matching slot; at most one slot matches.
    always_comb begin
        w_found     = 1'b0;
        w_found_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_found     = w_found | w_eq[i];
            w_found_cnt = w_found_cnt | (w_eq[i] ? w_cnt[i] : '0);
        end
    end

    // Slot selected by the scan counter during a minimum run.
    assign w_scan_cnt = w_cnt[r_idx];
    assign w_scan_key = w_key[r_idx];

    // Next state, slot command and output register load.
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_min       = r_min;
        n_mval      = r_mval && !m_axis_tready;
        n_mult      = r_mult;
        n_mkey      = r_mkey;
        n_dist      = r_dist;
        n_stat      = r_stat;
        n_last      = r_last;
        w_cmd.act   = ACT_HOLD;
        w_new_count = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mval = 1'b1;
                    n_mult = '0;
                    n_mkey = s_axis_tdata[OP_W+KEY_W-1:OP_W];
                    n_stat = STAT_OK;
                    n_last = 1'b1;
                    unique case (w_op)
                        OP_ADD: begin
                            if (w_found) begin
                                if (w_found_cnt == COUNT_MAX) begin
                                    n_mult = MULT_W'(w_found_cnt);
                                    n_stat = STAT_SAT;
                                end else begin
                                    w_cmd.act   = ACT_UPDATE;
                                    w_new_count = w_found_cnt + COUNT_BITS'(1);
                                    n_mult      = MULT_W'(w_new_count);
                                end
                            end else if (r_occ == OW'(ENTRIES)) begin
                                n_stat = STAT_FULL;
                            end else begin
                                w_cmd.act   = ACT_INSERT;
                                w_new_count = COUNT_BITS'(1);
                                n_mult      = MULT_W'(1);
                                n_occ       = r_occ + OW'(1);
                            end
                        end
                        OP_COUNT: begin
                            if (w_found) begin
                                n_mult = MULT_W'(w_found_cnt);
                            end else begin
                                n_stat = STAT_ABSENT;
                            end
                        end
                        OP_REMOVE_ONE: begin
                            if (w_found) begin
                                w_new_count = w_found_cnt - COUNT_BITS'(1);
                                n_mult      = MULT_W'(w_new_count);
                                if (w_new_count == '0) begin
                                    w_cmd.act = ACT_DROP;
                                    n_occ     = r_occ - OW'(1);
                                end else begin
                                    w_cmd.act = ACT_UPDATE;
                                end
                            end else begin
                                n_stat = STAT_ABSENT;
                            end
                        end
                        OP_REMOVE_ALL: begin
                            if (w_found) begin
                                w_cmd.act = ACT_DROP;
                                n_occ     = r_occ - OW'(1);
                            end else begin
                                n_stat = STAT_ABSENT;
                            end
                        end
                        OP_MIN_RUN: begin
                            if (r_occ == '0) begin
                                n_mkey = '0;
                                n_stat = STAT_ABSENT;
                            end else begin
                                // Result comes later from the emit pass.
                                n_mval     = 1'b0;
                                n_state    = ST_MIN;
                                n_idx      = '0;
                                n_last_idx = '0;
                                n_min      = COUNT_MAX;
                            end
                        end
                        default: begin
                            n_stat = STAT_ABSENT;
                        end
                    endcase
                    n_dist = DIST_W'(n_occ);
                end
            end

            ST_MIN: begin
                // Running minimum; ties move the last-match index forward.
                if (w_scan_cnt <= r_min) begin
                    n_min      = w_scan_cnt;
                    n_last_idx = r_idx;
                end
                if ((OW'(r_idx) + OW'(1)) == r_occ) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            ST_EMIT: begin
                if (w_scan_cnt == r_min) begin
                    if (w_out_free) begin
                        n_mval = 1'b1;
                        n_mult = MULT_W'(r_min);
                        n_mkey = KEY_W'(w_scan_key);
                        n_dist = DIST_W'(r_occ);
                        n_stat = STAT_OK;
                        n_last = (r_idx == r_last_idx);
                        if (r_idx == r_last_idx) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_mval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_mval  <= n_mval;
        end
    end

    // Scan and output payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_min      <= n_min;
        r_mult     <= n_mult;
        r_mkey     <= n_mkey;
        r_dist     <= n_dist;
        r_stat     <= n_stat;
        r_last     <= n_last;
    end

    assign m_axis_tvalid = r_mval;
    assign m_axis_tdata  = {1'b0, r_stat, r_dist, r_mkey, r_mult};
    assign m_axis_tlast  = r_last;

endmodule
